// ===== src/kte_pkg.sv =====
// kte_pkg: shared types and constants for the key to escape sequence encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kte_pkg;

  // Longest sequence emitted for one key (ESC [ 1 5 ~).
  localparam int SEQ_MAX   = 5;
  localparam int SEQ_LEN_W = $clog2(SEQ_MAX + 1);
  localparam int SEQ_IDX_W = $clog2(SEQ_MAX);

  // Depth of the queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration register indexes.
  localparam logic CFG_CURSOR_APP_MODE = 1'b0;
  localparam logic CFG_LINK_ACTIVE     = 1'b1;

  // Modifier bits.
  localparam int MOD_RSHIFT = 0;
  localparam int MOD_LSHIFT = 1;
  localparam int MOD_CTRL   = 2;
  localparam int MOD_ALT    = 3;

  localparam logic [7:0] ESC_BYTE  = 8'h1b;
  localparam logic [7:0] DEL_BYTE  = 8'h7f;
  localparam logic [7:0] CR_BYTE   = 8'h0d;
  localparam logic [7:0] LF_BYTE   = 8'h0a;
  localparam logic [7:0] BS_BYTE   = 8'h08;
  localparam logic [7:0] CTRL_MASK = 8'h1f;

  // Scan codes.
  localparam logic [7:0] SCAN_TAB      = 8'd43;
  localparam logic [7:0] SCAN_UP       = 8'd82;
  localparam logic [7:0] SCAN_DOWN     = 8'd81;
  localparam logic [7:0] SCAN_RIGHT    = 8'd79;
  localparam logic [7:0] SCAN_LEFT     = 8'd80;
  localparam logic [7:0] SCAN_HOME     = 8'd74;
  localparam logic [7:0] SCAN_END      = 8'd77;
  localparam logic [7:0] SCAN_INSERT   = 8'd73;
  localparam logic [7:0] SCAN_DELETE   = 8'd76;
  localparam logic [7:0] SCAN_PAGEUP   = 8'd75;
  localparam logic [7:0] SCAN_PAGEDOWN = 8'd78;
  localparam logic [7:0] SCAN_F1       = 8'd58;
  localparam logic [7:0] SCAN_F2       = 8'd59;
  localparam logic [7:0] SCAN_F3       = 8'd60;
  localparam logic [7:0] SCAN_F4       = 8'd61;
  localparam logic [7:0] SCAN_F5       = 8'd62;
  localparam logic [7:0] SCAN_F6       = 8'd63;
  localparam logic [7:0] SCAN_F7       = 8'd64;
  localparam logic [7:0] SCAN_F8       = 8'd65;
  localparam logic [7:0] SCAN_F9       = 8'd66;
  localparam logic [7:0] SCAN_F10      = 8'd67;
  localparam logic [7:0] SCAN_F11      = 8'd68;
  localparam logic [7:0] SCAN_F12      = 8'd69;

  typedef struct packed {
    logic [15:0] key_code;
    logic [3:0]  modifier_flags;
  } kte_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } kte_out_t;

  // One classified key: byte 0 goes out first.
  typedef struct packed {
    logic [SEQ_LEN_W-1:0]        seq_len;
    logic [SEQ_MAX-1:0][7:0]     seq_bytes;
  } kte_seq_t;

endpackage

// ===== src/key_to_escape_sequence_encoder_top.sv =====
// Key to escape sequence encoder: VT100-style terminal byte sequences from key events.
// Depends on kte_pkg, kte_front, kte_fifo and kte_back.
`timescale 1ns / 1ps

// Takes one key event per input transaction (scan code in key_code[15:8],
// character in key_code[7:0], modifier flags) and returns its terminal byte
// sequence, one byte per output transaction, with last_byte set on the final
// byte. Keys that produce nothing (link down, zero character with no special
// scan code) are absorbed and never show up on the output side. The front
// classifies a key in the cycle it is accepted and writes the whole sequence
// into a two-entry queue; the back loads the head into its sequence register
// and shifts out one byte per cycle while out_pop is held, taking the next
// sequence in the cycle the final byte is popped. A key's sequence (1 to 5
// bytes) is written into the queue, then loaded into the back's register,
// before its first byte appears. Input is taken every cycle while the queue
// has room, also while a result waits to be popped. Configuration (index 0:
// cursor_app_mode, reset 0; index 1: link_active, reset 1) takes effect on
// keys accepted after the write and is meant to be written while idle.

module key_to_escape_sequence_encoder_top import kte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  // input transactions
  input  logic     in_push,
  output logic     in_full,
  input  kte_in_t  in_data,
  // output transactions
  output logic     out_empty,
  input  logic     out_pop,
  output kte_out_t out_data,
  // configuration
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic     cfg_wdata
);

  kte_seq_t seq_cls, q_head;
  logic     q_push, q_full, q_pop, q_empty;

  kte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .key_in    (in_data),
    .seq_out   (seq_cls)
  );

  // Empty sequences are dropped at the door.
  assign in_full = q_full;
  assign q_push  = in_push && (seq_cls.seq_len != '0);

  kte_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (seq_cls),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  kte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

// ===== src/kte_front.sv =====
// kte_front: configuration registers and key classification into a byte sequence.
// Depends on kte_pkg.
`timescale 1ns / 1ps

module kte_front import kte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic     cfg_wdata,
  input  kte_in_t  key_in,
  output kte_seq_t seq_out
);

  logic cursor_app_r, cursor_app_nxt;
  logic link_active_r, link_active_nxt;

  always_comb begin
    cursor_app_nxt  = cursor_app_r;
    link_active_nxt = link_active_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CURSOR_APP_MODE: cursor_app_nxt  = cfg_wdata;
        CFG_LINK_ACTIVE:     link_active_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_app_r  <= 1'b0;
      link_active_r <= 1'b1;
    end else begin
      cursor_app_r  <= cursor_app_nxt;
      link_active_r <= link_active_nxt;
    end
  end

  function automatic kte_seq_t mk_seq(input logic [SEQ_LEN_W-1:0] len,
                                      input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [7:0] b3,
                                      input logic [7:0] b4);
    kte_seq_t s;
    s.seq_len      = len;
    s.seq_bytes[0] = b0;
    s.seq_bytes[1] = b1;
    s.seq_bytes[2] = b2;
    s.seq_bytes[3] = b3;
    s.seq_bytes[4] = b4;
    return s;
  endfunction

  logic [7:0] scan, ch, ch_map, csi_or_ss3;
  logic       shift, ctrl, alt;

  assign scan       = key_in.key_code[15:8];
  assign ch         = key_in.key_code[7:0];
  assign shift      = key_in.modifier_flags[MOD_RSHIFT] | key_in.modifier_flags[MOD_LSHIFT];
  assign ctrl       = key_in.modifier_flags[MOD_CTRL];
  assign alt        = key_in.modifier_flags[MOD_ALT];
  assign csi_or_ss3 = cursor_app_r ? "O" : "[";

  always_comb begin
    if (ch == BS_BYTE || ch == DEL_BYTE) begin
      ch_map = DEL_BYTE;
    end else if (ch == LF_BYTE || ch == CR_BYTE) begin
      ch_map = CR_BYTE;
    end else begin
      ch_map = ch;
    end
  end

  always_comb begin
    seq_out = '0;
    if (!link_active_r) begin
      seq_out = '0;
    end else if (scan == SCAN_TAB && shift) begin
      seq_out = mk_seq(3'd3, ESC_BYTE, "[", "Z", 8'h00, 8'h00);
    end else begin
      case (scan)
        SCAN_UP:       seq_out = mk_seq(3'd3, ESC_BYTE, csi_or_ss3, "A", 8'h00, 8'h00);
        SCAN_DOWN:     seq_out = mk_seq(3'd3, ESC_BYTE, csi_or_ss3, "B", 8'h00, 8'h00);
        SCAN_RIGHT:    seq_out = mk_seq(3'd3, ESC_BYTE, csi_or_ss3, "C", 8'h00, 8'h00);
        SCAN_LEFT:     seq_out = mk_seq(3'd3, ESC_BYTE, csi_or_ss3, "D", 8'h00, 8'h00);
        SCAN_HOME:     seq_out = mk_seq(3'd3, ESC_BYTE, "[", "H", 8'h00, 8'h00);
        SCAN_END:      seq_out = mk_seq(3'd3, ESC_BYTE, "[", "F", 8'h00, 8'h00);
        SCAN_INSERT:   seq_out = mk_seq(3'd4, ESC_BYTE, "[", "2", "~", 8'h00);
        SCAN_DELETE:   seq_out = mk_seq(3'd4, ESC_BYTE, "[", "3", "~", 8'h00);
        SCAN_PAGEUP:   seq_out = mk_seq(3'd4, ESC_BYTE, "[", "5", "~", 8'h00);
        SCAN_PAGEDOWN: seq_out = mk_seq(3'd4, ESC_BYTE, "[", "6", "~", 8'h00);
        SCAN_F1:       seq_out = mk_seq(3'd3, ESC_BYTE, "O", "P", 8'h00, 8'h00);
        SCAN_F2:       seq_out = mk_seq(3'd3, ESC_BYTE, "O", "Q", 8'h00, 8'h00);
        SCAN_F3:       seq_out = mk_seq(3'd3, ESC_BYTE, "O", "R", 8'h00, 8'h00);
        SCAN_F4:       seq_out = mk_seq(3'd3, ESC_BYTE, "O", "S", 8'h00, 8'h00);
        SCAN_F5:       seq_out = mk_seq(3'd5, ESC_BYTE, "[", "1", "5", "~");
        SCAN_F6:       seq_out = mk_seq(3'd5, ESC_BYTE, "[", "1", "7", "~");
        SCAN_F7:       seq_out = mk_seq(3'd5, ESC_BYTE, "[", "1", "8", "~");
        SCAN_F8:       seq_out = mk_seq(3'd5, ESC_BYTE, "[", "1", "9", "~");
        SCAN_F9:       seq_out = mk_seq(3'd5, ESC_BYTE, "[", "2", "0", "~");
        SCAN_F10:      seq_out = mk_seq(3'd5, ESC_BYTE, "[", "2", "1", "~");
        SCAN_F11:      seq_out = mk_seq(3'd5, ESC_BYTE, "[", "2", "3", "~");
        SCAN_F12:      seq_out = mk_seq(3'd5, ESC_BYTE, "[", "2", "4", "~");
        default: begin
          if (ch == 8'h00) begin
            seq_out = '0;
          end else if (ctrl && ch inside {[8'd64:8'd127]}) begin
            seq_out = mk_seq(3'd1, ch & CTRL_MASK, 8'h00, 8'h00, 8'h00, 8'h00);
          end else if (alt) begin
            seq_out = mk_seq(3'd2, ESC_BYTE, ch_map, 8'h00, 8'h00, 8'h00);
          end else begin
            seq_out = mk_seq(3'd1, ch_map, 8'h00, 8'h00, 8'h00, 8'h00);
          end
        end
      endcase
    end
  end

endmodule

// ===== src/kte_fifo.sv =====
// kte_fifo: short register queue of classified sequences between front and back.
// Depends on kte_pkg.
`timescale 1ns / 1ps

module kte_fifo import kte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  kte_seq_t push_data,
  output logic     full,
  input  logic     pop,
  output kte_seq_t head,
  output logic     empty
);

  kte_seq_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/kte_back.sv =====
// kte_back: serializes one queued sequence into bytes, one per output transaction.
// Depends on kte_pkg.
`timescale 1ns / 1ps

module kte_back import kte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  kte_seq_t q_head,
  input  logic     q_empty,
  output logic     q_pop,
  output kte_out_t out_data,
  output logic     out_empty,
  input  logic     out_pop
);

  kte_seq_t             cur_r, cur_nxt;
  logic [SEQ_IDX_W-1:0] idx_r, idx_nxt;
  logic                 vld_r, vld_nxt;
  logic                 is_last, load;

  assign is_last            = (SEQ_LEN_W'(idx_r) == cur_r.seq_len - 1'b1);
  assign out_empty          = !vld_r;
  assign out_data.out_byte  = cur_r.seq_bytes[idx_r];
  assign out_data.last_byte = is_last;

  // Take a new sequence when idle or when the final byte leaves this cycle.
  assign load  = !vld_r || (out_pop && is_last);
  assign q_pop = load && !q_empty;

  always_comb begin
    cur_nxt = cur_r;
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = !q_empty;
      cur_nxt = q_head;
      idx_nxt = '0;
    end else if (out_pop) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

// ===== src/kte_checker.sv =====
// kte_checker: port-level assertions for the encoder top, attached by bind.
// Depends on kte_pkg and key_to_escape_sequence_encoder_top.
`timescale 1ns / 1ps

module kte_checker import kte_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_full,
  input logic     out_empty,
  input logic     out_pop,
  input kte_out_t out_data
);

  // Reset leaves both sides idle.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("not idle after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled result changed");

  // The rest of a sequence follows at once.
  a_seq_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_data.last_byte) |=> !out_empty)
    else $error("sequence broken off");

  // A shown result is always fully defined.
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !$isunknown(out_data))
    else $error("unknown bits on shown result");

endmodule

bind key_to_escape_sequence_encoder_top kte_checker u_kte_checker (.*);

// ===== tb/tb_key_to_escape_sequence_encoder_top.sv =====
// Self-checking testbench for key_to_escape_sequence_encoder_top: drives key events, predicts
// the VT byte sequences and checks every popped byte in order.
// Depends on kte_pkg and the RTL of the encoder.
`timescale 1ns / 1ps

module tb_key_to_escape_sequence_encoder_top;
  import kte_pkg::*;

  localparam int DRAIN_CYCLES = 8;     // quiet cycles after the last byte before a config write
  localparam int STALL_LIMIT  = 1000;  // cycles with no transaction before the run is abandoned

  localparam logic [3:0] M_RSH  = 4'b1 << MOD_RSHIFT;
  localparam logic [3:0] M_LSH  = 4'b1 << MOD_LSHIFT;
  localparam logic [3:0] M_CTRL = 4'b1 << MOD_CTRL;
  localparam logic [3:0] M_ALT  = 4'b1 << MOD_ALT;

  // Mirrors the two config registers and holds the bytes still owed by the DUT.
  class key_seq_tracker;
    bit       app_mode;
    bit       link_up;
    kte_out_t pending_bytes[$];
    int       mismatch_count;

    function new();
      app_mode       = 1'b0;
      link_up        = 1'b1;
      mismatch_count = 0;
    endfunction

    function void push_byte(logic [7:0] b, logic last);
      kte_out_t e;
      e.out_byte  = b;
      e.last_byte = last;
      pending_bytes.push_back(e);
    endfunction

    // ESC, then the tail; last flag on the final byte
    function void push_esc_seq(string tail);
      push_byte(ESC_BYTE, 1'b0);
      for (int i = 0; i < tail.len(); i++)
        push_byte(tail[i], i == tail.len() - 1);
    endfunction

    function void note_key(kte_in_t k);
      logic [7:0] scan;
      logic [7:0] ch;
      logic [3:0] mods;
      scan = k.key_code[15:8];
      ch   = k.key_code[7:0];
      mods = k.modifier_flags;
      if (!link_up) return;
      if (scan == SCAN_TAB && (mods[MOD_RSHIFT] || mods[MOD_LSHIFT])) begin
        push_esc_seq("[Z");
        return;
      end
      case (scan)
        SCAN_UP:       push_esc_seq(app_mode ? "OA" : "[A");
        SCAN_DOWN:     push_esc_seq(app_mode ? "OB" : "[B");
        SCAN_RIGHT:    push_esc_seq(app_mode ? "OC" : "[C");
        SCAN_LEFT:     push_esc_seq(app_mode ? "OD" : "[D");
        SCAN_HOME:     push_esc_seq("[H");
        SCAN_END:      push_esc_seq("[F");
        SCAN_INSERT:   push_esc_seq("[2~");
        SCAN_DELETE:   push_esc_seq("[3~");
        SCAN_PAGEUP:   push_esc_seq("[5~");
        SCAN_PAGEDOWN: push_esc_seq("[6~");
        SCAN_F1:       push_esc_seq("OP");
        SCAN_F2:       push_esc_seq("OQ");
        SCAN_F3:       push_esc_seq("OR");
        SCAN_F4:       push_esc_seq("OS");
        SCAN_F5:       push_esc_seq("[15~");
        SCAN_F6:       push_esc_seq("[17~");
        SCAN_F7:       push_esc_seq("[18~");
        SCAN_F8:       push_esc_seq("[19~");
        SCAN_F9:       push_esc_seq("[20~");
        SCAN_F10:      push_esc_seq("[21~");
        SCAN_F11:      push_esc_seq("[23~");
        SCAN_F12:      push_esc_seq("[24~");
        default: begin
          if (ch == 8'h00) return;
          // control folding covers '@' through DEL, no ESC prefix
          if (mods[MOD_CTRL] && ch >= 8'h40 && ch <= DEL_BYTE) begin
            push_byte(ch & CTRL_MASK, 1'b1);
          end else begin
            if (ch == BS_BYTE || ch == DEL_BYTE) ch = DEL_BYTE;
            else if (ch == LF_BYTE || ch == CR_BYTE) ch = CR_BYTE;
            if (mods[MOD_ALT]) push_byte(ESC_BYTE, 1'b0);
            push_byte(ch, 1'b1);
          end
        end
      endcase
    endfunction

    function void check_byte(kte_out_t got);
      kte_out_t want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual byte %02h last %0b",
                 $time, got.out_byte, got.last_byte);
        mismatch_count++;
        return;
      end
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                 $time, want.out_byte, got.out_byte);
        mismatch_count++;
      end
      if (got.last_byte !== want.last_byte) begin
        $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                 $time, want.last_byte, got.last_byte);
        mismatch_count++;
      end
    endfunction
  endclass

  // All DUT inputs start at known values; reset is held low from time zero.
  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_push   = 1'b0;
  kte_in_t  in_data   = '0;
  logic     out_pop   = 1'b0;
  logic     cfg_we    = 1'b0;
  logic     cfg_index = 1'b0;
  logic     cfg_wdata = 1'b0;
  logic     in_full;
  logic     out_empty;
  kte_out_t out_data;

  bit calm = 1'b0;  // set for the stretch with no idling on either side
  int idle_cycles = 0;
  key_seq_tracker tracker;

  always #6 clk = ~clk;

  key_to_escape_sequence_encoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Monitor. Sampling at the edge sees the pre-edge values of both the DUT
  // registers and our own NBA-driven inputs, i.e. exactly what the DUT used.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) tracker.note_key(in_data);
      if (out_pop && !out_empty) tracker.check_byte(out_data);
    end
  end

  // Result side: pop most cycles, hold off about 16 in 100 unless calm.
  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= calm || ($urandom_range(99) >= 16);
  end

  // Watchdog: a run with no transaction for too long is stuck.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic kte_in_t mk_key(logic [7:0] scan, logic [7:0] ch, logic [3:0] mods);
    kte_in_t k;
    k.key_code       = {scan, ch};
    k.modifier_flags = mods;
    return k;
  endfunction

  // Special keys, Tab and the characters with their own rules are favoured, random mods on top;
  // a slice of fully random codes makes every bit toggle.
  function automatic kte_in_t random_key();
    logic [7:0] scan;
    logic [7:0] ch;
    int pick;
    pick = $urandom_range(99);
    ch   = 8'($urandom_range(255));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(7))
        0:       ch = 8'h00;
        1:       ch = BS_BYTE;
        2:       ch = LF_BYTE;
        3:       ch = CR_BYTE;
        4:       ch = DEL_BYTE;
        5:       ch = 8'h40;
        6:       ch = 8'h3f;
        default: ch = 8'h80;
      endcase
    end
    if (pick < 35) scan = 8'($urandom_range(SCAN_F1, SCAN_UP));  // F keys through cursor keys
    else if (pick < 45) scan = SCAN_TAB;
    else scan = 8'($urandom_range(255));
    if (pick >= 85) begin
      return mk_key(8'($urandom_range(255)), 8'($urandom_range(255)),
                    4'($urandom_range(15)));
    end
    return mk_key(scan, ch, 4'($urandom_range(15)));
  endfunction

  // One input transaction; random idle cycles ahead of it unless calm.
  task automatic drive_key(kte_in_t k);
    while (!calm && $urandom_range(99) < 16) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= k;
    do @(posedge clk); while (in_full);
  endtask

  // Wait until every owed byte has come out, then give absorbed keys time to clear.
  // The first edge lets the monitor note a key accepted in this very step.
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (tracker.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers, back to back; only called while the DUT is idle.
  task automatic write_config(bit app, bit link);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CURSOR_APP_MODE;
    cfg_wdata <= app;
    @(posedge clk);
    cfg_index <= CFG_LINK_ACTIVE;
    cfg_wdata <= link;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.app_mode = app;
    tracker.link_up  = link;
  endtask

  initial begin
    // per phase: cursor mode, link state, item count; phase 3 runs without idling,
    // the last phase picks its settings at random
    bit app_set[6];
    bit link_set[6];
    int n_items[6];
    bit app_v;
    bit link_v;

    app_set  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    link_set = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
    n_items  = '{50, 20, 15, 50, 50, 60};
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings: every special key class, Shift+Tab with
    // either shift, Tab without shift, zero character, control folding at both
    // ends of its range and just below it, BS/LF/CR mapping, Alt prefix,
    // and the all-zero and all-one codes.
    drive_key(mk_key(SCAN_UP,       8'h00, 4'h0));
    drive_key(mk_key(SCAN_DOWN,     "x",   4'hf));
    drive_key(mk_key(SCAN_RIGHT,    8'h00, M_ALT));
    drive_key(mk_key(SCAN_LEFT,     8'h00, M_CTRL));
    drive_key(mk_key(SCAN_HOME,     8'h00, 4'h0));
    drive_key(mk_key(SCAN_END,      8'h00, 4'h0));
    drive_key(mk_key(SCAN_INSERT,   8'h00, 4'h0));
    drive_key(mk_key(SCAN_DELETE,   DEL_BYTE, 4'h0));
    drive_key(mk_key(SCAN_PAGEUP,   8'h00, 4'h0));
    drive_key(mk_key(SCAN_PAGEDOWN, 8'h00, 4'h0));
    drive_key(mk_key(SCAN_F1,       8'h00, 4'h0));
    drive_key(mk_key(SCAN_F5,       8'h00, 4'h0));
    drive_key(mk_key(SCAN_F12,      8'h00, 4'h0));
    drive_key(mk_key(SCAN_TAB,      8'h09, M_RSH));
    drive_key(mk_key(SCAN_TAB,      8'h09, M_LSH | M_ALT));
    drive_key(mk_key(SCAN_TAB,      8'h09, 4'h0));
    drive_key(mk_key(8'h00,         8'h00, 4'h0));
    drive_key(mk_key(8'h00,         "a",   M_CTRL));
    drive_key(mk_key(8'h00,         "@",   M_CTRL | M_ALT));
    drive_key(mk_key(8'h00,         DEL_BYTE, M_CTRL));
    drive_key(mk_key(8'h00,         "?",   M_CTRL | M_ALT));
    drive_key(mk_key(8'h00,         BS_BYTE, M_ALT));
    drive_key(mk_key(8'h00,         LF_BYTE, 4'h0));
    drive_key(mk_key(8'h00,         CR_BYTE, 4'h0));
    drive_key(mk_key(8'hff,         8'hff, 4'hf));
    settle();

    // Random part, one config setting per phase, written while idle.
    for (int phase = 0; phase < 6; phase++) begin
      app_v  = app_set[phase];
      link_v = link_set[phase];
      if (phase == 5) begin
        app_v  = 1'($urandom_range(1));
        link_v = 1'($urandom_range(1));
      end
      write_config(app_v, link_v);
      calm = (phase == 3);
      for (int n = 0; n < n_items[phase]; n++)
        drive_key(random_key());
      settle();
    end
    calm = 1'b0;

    if (tracker.mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
